// ----- sv/bsmg_pkg.sv -----
package bsmg_pkg;

  localparam int VW = 32;
  localparam logic [VW-1:0] BIAS = 32'h8000_0000;
  localparam logic [6:0] CAP_RESET = 7'd64;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_GAP
  } bsmg_state_t;

  // What one cell shows its right-hand neighbor
  typedef struct packed {
    logic [VW-1:0] val;
    logic          le;
    logic          is_new;
  } bsmg_link_t;

  // Neighbor values of the newly inserted entry, one-hot across the row
  typedef struct packed {
    logic [VW-1:0] pred;
    logic [VW-1:0] succ;
    logic          has_pred;
    logic          has_succ;
  } bsmg_cand_t;

endpackage

// ----- sv/bsmg_cell.sv -----
module bsmg_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                        clk,
  input  logic                        ins_en,
  input  logic [bsmg_pkg::VW-1:0]     x,
  input  logic [CW-1:0]               eff_count,
  input  logic [CW-1:0]               held_count,
  input  bsmg_pkg::bsmg_link_t        left,
  input  logic                        right_new,
  output bsmg_pkg::bsmg_link_t        link,
  output bsmg_pkg::bsmg_cand_t        cand
);
  import bsmg_pkg::*;

  logic [VW-1:0] val_r;
  logic [VW-1:0] val_nxt;
  logic          is_new_r;
  logic          is_new_nxt;
  logic          le;
  logic          occupied;

  assign occupied = CW'(IDX) < eff_count;
  assign le       = occupied && (val_r <= x);

  // keep, take the new value, or shift in from the left
  always_comb begin
    if (le) begin
      val_nxt = val_r;
    end else if (left.le) begin
      val_nxt = x;
    end else begin
      val_nxt = left.val;
    end
    is_new_nxt = !le && left.le;
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      val_r    <= val_nxt;
      is_new_r <= is_new_nxt;
    end
  end

  assign link = '{val: val_r, le: le, is_new: is_new_r};

  always_comb begin
    cand.has_pred = right_new;
    cand.has_succ = left.is_new && (CW'(IDX) < held_count);
    cand.pred     = right_new ? val_r : '0;
    cand.succ     = cand.has_succ ? val_r : '0;
  end

endmodule

// ----- sv/bsmg_pick.sv -----
module bsmg_pick #(
  parameter int DEPTH = 64
) (
  input  bsmg_pkg::bsmg_cand_t cand [DEPTH],
  output bsmg_pkg::bsmg_cand_t sel
);
  import bsmg_pkg::*;

  logic [$bits(bsmg_cand_t)-1:0] acc;

  // at most one cell drives each field, so an OR merges them
  always_comb begin
    acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      acc = acc | cand[i];
    end
  end

  assign sel = acc;

endmodule

// ----- sv/bounded_set_min_gap_and_range.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_value, in_start_new
// out     | output    | out_valid / out_ready | out_status, out_shortest_span,
//         |           |                       | out_longest_span, out_count
// cfg     | input     | cfg_wr_en             | cfg_wr_data (capacity)
//
// An item goes in order: insert into the cell row, select the new entry's
// neighbors across the row, then update the smallest gap into the output register.
// The next item is taken only once the result is registered, so items never overlap.
// Reset (synchronous, rst_n low) empties the set and sets capacity to 64.
// A stalled output holds the block in its gap stage until the transfer.
module bounded_set_min_gap_and_range #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_start_new,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_shortest_span,
  output logic [31:0]        out_longest_span,
  output logic [6:0]         out_count,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);
  import bsmg_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  function automatic logic [VW-1:0] min_pos(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW-1:0] r;
    if (a == '0) begin
      r = b;
    end else if (b == '0) begin
      r = a;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

  bsmg_state_t state_r;
  bsmg_state_t state_nxt;

  logic [6:0]    cap_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] eff_count;
  logic [VW-1:0] best_r;
  logic [VW-1:0] best_nxt;
  logic [VW-1:0] min_r;
  logic [VW-1:0] max_r;
  logic [VW-1:0] x_r;
  logic [VW-1:0] x_in;
  logic          refused_r;
  logic          full;
  logic          accept;
  logic          ins_en;
  logic          pick_load;
  logic          res_load;
  bsmg_cand_t    pick_r;
  bsmg_cand_t    pick_sel;

  logic [VW-1:0] gap_lo;
  logic [VW-1:0] gap_hi;
  logic          few;
  logic [LW-1:0] count_ext;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [VW-1:0] out_short_r;
  logic [VW-1:0] out_long_r;
  logic [6:0]    out_count_r;

  bsmg_link_t    link [DEPTH+1];
  bsmg_cand_t    cand [DEPTH];
  logic [DEPTH-1:0] newv;

  assign x_in      = $unsigned(in_value) ^ BIAS;
  assign eff_count = in_start_new ? '0 : count_r;
  assign full      = (LW'(eff_count) >= LW'(DEPTH)) || (LW'(eff_count) >= LW'(cap_r));
  assign accept    = in_valid && in_ready;
  assign ins_en    = accept && !full;

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_GAP;
      ST_GAP:  if (res_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    pick_load = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = rst_n;
      ST_PICK: pick_load = 1'b1;
      ST_GAP:  res_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // cell row
  assign link[0] = '{val: '0, le: 1'b1, is_new: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic right_new;
    if (i == DEPTH - 1) begin : g_last
      assign right_new = 1'b0;
    end else begin : g_mid
      assign right_new = link[i+2].is_new;
    end

    bsmg_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ins_en     (ins_en),
      .x          (x_in),
      .eff_count  (eff_count),
      .held_count (count_r),
      .left       (link[i]),
      .right_new  (right_new),
      .link       (link[i+1]),
      .cand       (cand[i])
    );

    assign newv[i] = link[i+1].is_new;
  end

  bsmg_pick #(
    .DEPTH (DEPTH)
  ) u_pick (
    .cand (cand),
    .sel  (pick_sel)
  );

  // smallest positive gap after the insert
  always_comb begin
    gap_lo = pick_r.has_pred ? (x_r - pick_r.pred) : '0;
    gap_hi = pick_r.has_succ ? (pick_r.succ - x_r) : '0;
    if (refused_r) begin
      best_nxt = best_r;
    end else begin
      best_nxt = min_pos(min_pos(best_r, gap_lo), gap_hi);
    end
  end

  assign few       = count_r < CW'(2);
  assign count_ext = LW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        count_r <= full ? eff_count : eff_count + CW'(1);
        if (in_start_new) begin
          best_r <= '0;
        end
      end
      if (res_load) begin
        best_r <= best_nxt;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= x_in;
      refused_r <= full;
    end
    if (ins_en) begin
      if (eff_count == '0) begin
        min_r <= x_in;
        max_r <= x_in;
      end else begin
        if (x_in < min_r) min_r <= x_in;
        if (x_in > max_r) max_r <= x_in;
      end
    end
    if (pick_load) begin
      pick_r <= pick_sel;
    end
    if (res_load) begin
      out_status_r <= refused_r ? STAT_FULL : (few ? STAT_FEW : STAT_OK);
      out_short_r  <= few ? '0 : best_nxt;
      out_long_r   <= few ? '0 : (max_r - min_r);
      out_count_r  <= count_ext[6:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_shortest_span = out_short_r;
  assign out_longest_span  = out_long_r;
  assign out_count         = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(DEPTH))
    else $error("held count beyond DEPTH");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> count_r == $past(eff_count) + CW'(1))
    else $error("insert did not advance the count by one");

  a_one_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && !refused_r) |-> $onehot(newv))
    else $error("insert point not unique across the cell row");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GAP && count_r != '0) |-> min_r <= max_r)
    else $error("set minimum above maximum");

endmodule

// ----- tb/tb_bounded_set_min_gap_and_range.sv -----
`timescale 1ns / 1ps

module tb_bounded_set_min_gap_and_range;
  import bsmg_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] shortest;
    logic [31:0] longest;
    logic [6:0]  count;
  } span_result_t;

  typedef enum int {
    SHAPE_SPREAD,
    SHAPE_CLUSTER,
    SHAPE_EXTREME,
    SHAPE_RAMP,
    SHAPE_MIXED
  } shape_t;

  class gap_range_tracker;
    logic [31:0]  held[$];       // biased values, ascending
    int           cap_limit;
    span_result_t pending_q[$];
    int           errors;

    function new();
      cap_limit = DEPTH;
      errors = 0;
    endfunction

    function void set_capacity(logic [6:0] c);
      cap_limit = (c > DEPTH) ? DEPTH : int'(c);
    endfunction

    function void note_input(logic [31:0] v, logic start_new);
      logic [31:0]  b;
      logic [31:0]  d;
      int           pos;
      span_result_t r;
      b = v ^ BIAS;
      if (start_new) held.delete();
      if (held.size() < cap_limit) begin
        pos = held.size();
        while (pos > 0 && held[pos-1] > b) pos--;
        held.insert(pos, b);
        r.status = (held.size() < 2) ? STAT_FEW : STAT_OK;
      end else begin
        r.status = STAT_FULL;
      end
      r.shortest = '0;
      r.longest = '0;
      if (held.size() >= 2) begin
        r.longest = held[$] - held[0];
        for (int i = 1; i < held.size(); i++) begin
          d = held[i] - held[i-1];
          // equal neighbors never count as the smallest gap
          if (d != 0 && (r.shortest == 0 || d < r.shortest)) r.shortest = d;
        end
      end
      r.count = 7'(held.size());
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check(logic [1:0] st, logic [31:0] sh, logic [31:0] lo, logic [6:0] cnt);
      span_result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with no input pending");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $error("out_status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (sh !== e.shortest) begin
        $error("out_shortest_span: expected %h, got %h", e.shortest, sh);
        errors++;
      end
      if (lo !== e.longest) begin
        $error("out_longest_span: expected %h, got %h", e.longest, lo);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("out_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value = '0;
  logic               in_start_new = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [31:0]        out_shortest_span;
  logic [31:0]        out_longest_span;
  logic [6:0]         out_count;
  logic               cfg_wr_en = 1'b0;
  logic [6:0]         cfg_wr_data = '0;

  gap_range_tracker sb;
  int burst_left = 0;
  int ready_left = 0;
  logic ready_level = 1'b0;
  int cycles = 0;

  bounded_set_min_gap_and_range #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_start_new      (in_start_new),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_shortest_span (out_shortest_span),
    .out_longest_span  (out_longest_span),
    .out_count         (out_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: long ready stretches, stalls and random flicker
  always @(negedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_level = 1'b1;
          ready_left = $urandom_range(20, 60);
        end
        1: begin
          ready_level = 1'b0;
          ready_left = $urandom_range(1, 8);
        end
        default: begin
          ready_level = 1'($urandom_range(0, 1));
          ready_left = $urandom_range(1, 4);
        end
      endcase
    end
    ready_left--;
    out_ready <= ready_level;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check(out_status, out_shortest_span, out_longest_span, out_count);
  end

  task automatic send_item(input logic [31:0] v, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 5);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    in_start_new <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v, s);
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] c);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    // allow the gap stage to settle before touching the register
    repeat (6) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(c);
  endtask

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return MOST_NEG + 32'd1;
      default: return MOST_POS - 32'd1;
    endcase
  endfunction

  // One fill of the set: a start, then adds; now and then a broken one
  task automatic run_sequence(input int limit, inout int done);
    int          len;
    int          step;
    shape_t      shape;
    logic [31:0] base;
    logic [31:0] v;
    logic        s;
    logic        broken;
    logic        down;
    broken = ($urandom_range(0, 6) == 0);
    shape = shape_t'($urandom_range(0, 4));
    base = $urandom;
    step = $urandom_range(0, 1000);
    down = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) len = limit + $urandom_range(1, 6);
    else len = $urandom_range(1, limit + 8);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_SPREAD:  v = $urandom;
        SHAPE_CLUSTER: v = base + 32'($urandom_range(0, 20));
        SHAPE_EXTREME: v = extreme_value();
        SHAPE_RAMP:    v = down ? base - 32'(i * step) : base + 32'(i * step);
        default:       v = ($urandom_range(0, 1) == 0) ? extreme_value() : $urandom;
      endcase
      s = broken ? ($urandom_range(0, 9) == 0) : (i == 0);
      send_item(v, s);
      done++;
    end
  endtask

  task automatic run_phase(input logic [6:0] c, input int quota);
    int done;
    int limit;
    done = 0;
    limit = (c > DEPTH) ? DEPTH : int'(c);
    write_capacity(c);
    while (done < quota) run_sequence(limit, done);
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // capacity at its reset value
    send_item(MOST_NEG, 1'b1);
    send_item(MOST_POS, 1'b0);
    send_item(MOST_POS, 1'b0);
    send_item(32'h0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd7, 1'b1);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b0);
    // zero capacity refuses every add
    write_capacity(7'd0);
    send_item(32'd5, 1'b1);
    send_item(32'd9, 1'b0);
    // full set refuses, spans describe the kept pair
    write_capacity(7'd2);
    send_item(-32'sd3, 1'b1);
    send_item(32'd4, 1'b0);
    send_item(32'd100, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'd1, 1'b1);
    send_item(MOST_NEG, 1'b0);
    // capacity above the store depth clamps to it
    write_capacity(7'd127);
    send_item(MOST_POS, 1'b1);
    send_item(MOST_NEG, 1'b0);
    send_item(32'h0, 1'b0);
    // single entry set: refused add reports full, with both spans zero
    write_capacity(7'd1);
    send_item(32'd42, 1'b1);
    send_item(32'd43, 1'b0);

    run_phase(7'd64, 80);
    run_phase(7'd1, 50);
    run_phase(7'd2, 50);
    run_phase(7'd127, 80);
    run_phase(7'd0, 15);
    run_phase(7'd100, 80);
    run_phase(7'($urandom_range(3, 63)), 80);
    run_phase(7'd65, 80);
    run_phase(7'd64, 80);
    run_phase(7'($urandom_range(3, 63)), 80);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
